// ===== hdl/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 2'd1;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_PREP,
        ST_LD_SQ,
        ST_SQ,
        ST_SQ_END,
        ST_LD_MUL,
        ST_MUL,
        ST_MUL_END,
        ST_NEXT,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic ld_exp;     // capture exponent for bit scanning
        logic ld_div;     // start base reduction
        logic ld_sq;      // start acc * acc
        logic ld_mul;     // start acc * base
        logic step;       // one shift-add-reduce step
        logic save_base;  // base <= product
        logic init_acc;   // acc <= 1 (0 when modulus is 1)
        logic save_acc;   // acc <= product
        logic set_one;    // acc <= 1 unreduced, zero exponent
        logic shift_exp;  // move to next exponent bit
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic exp_zero;
        logic exp_msb;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/mexp_datapath.sv =====
`default_nettype none

module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WIDTH-1:0]     i_cfg_data,
    input  wire logic [WIDTH-1:0]     i_base_value,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_status                o_status,
    output logic [WIDTH-1:0]          o_power_result
);

    localparam int unsigned TW = WIDTH + 2;

    logic [WIDTH-1:0] r_modulus;
    logic [WIDTH-1:0] r_exponent;
    logic [WIDTH-1:0] r_eshift;
    logic [WIDTH-1:0] r_acc;
    logic [WIDTH-1:0] r_base;
    logic [WIDTH-1:0] r_mcand;
    logic [WIDTH-1:0] r_mplier;
    logic [WIDTH-1:0] r_prod;

    logic [WIDTH-1:0] n_prod;
    logic [TW-1:0]    t_sum;
    logic [TW-1:0]    m1;
    logic [TW-1:0]    m2;
    logic [TW-1:0]    t_red;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= WIDTH'(1);
            r_exponent <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODULUS:  r_modulus  <= i_cfg_data;
                REG_EXPONENT: r_exponent <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shift-add-reduce step: prod <= (2*prod + bit*mcand) mod m
    // operands stay below m, so the sum stays below 3m; m of zero wraps
    always_comb begin
        m1    = {2'b00, r_modulus};
        m2    = {1'b0, r_modulus, 1'b0};
        t_sum = {1'b0, r_prod, 1'b0} + (r_mplier[WIDTH-1] ? {2'b00, r_mcand} : '0);
        if (t_sum >= m2) begin
            t_red = t_sum - m2;
        end else if (t_sum >= m1) begin
            t_red = t_sum - m1;
        end else begin
            t_red = t_sum;
        end
        n_prod = t_red[WIDTH-1:0];
    end

    // operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_div) begin
            // base mod m by long division: mcand of one feeds dividend bits
            r_mcand  <= WIDTH'(1);
            r_mplier <= i_base_value;
            r_prod   <= '0;
        end else if (i_cmd.ld_sq) begin
            r_mcand  <= r_acc;
            r_mplier <= r_acc;
            r_prod   <= '0;
        end else if (i_cmd.ld_mul) begin
            r_mcand  <= r_base;
            r_mplier <= r_acc;
            r_prod   <= '0;
        end else if (i_cmd.step) begin
            r_mplier <= {r_mplier[WIDTH-2:0], 1'b0};
            r_prod   <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.save_base) begin
            r_base <= r_prod;
        end
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_one) begin
            r_acc <= WIDTH'(1);
        end else if (i_cmd.init_acc) begin
            r_acc <= (r_modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
        end else if (i_cmd.save_acc) begin
            r_acc <= r_prod;
        end
    end

    // exponent scan, MSB first
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_exp) begin
            r_eshift <= r_exponent;
        end else if (i_cmd.shift_exp) begin
            r_eshift <= {r_eshift[WIDTH-2:0], 1'b0};
        end
    end

    assign o_status.exp_zero = (r_exponent == '0);
    assign o_status.exp_msb  = r_eshift[WIDTH-1];
    assign o_power_result    = r_acc;

endmodule

`default_nettype wire

// ===== hdl/mexp_ctrl.sv =====
`default_nettype none

module mexp_ctrl
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    localparam int unsigned CW = $clog2(WIDTH);
    localparam logic [CW-1:0] LAST = CW'(WIDTH - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_bit, n_bit;

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bit   = r_bit;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.ld_exp = 1'b1;
                    if (i_status.exp_zero) begin
                        o_cmd.set_one = 1'b1;
                        n_state       = ST_DONE;
                    end else begin
                        o_cmd.ld_div = 1'b1;
                        n_cnt        = LAST;
                        n_state      = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.save_base = 1'b1;
                o_cmd.init_acc  = 1'b1;
                n_bit           = LAST;
                n_state         = ST_LD_SQ;
            end
            ST_LD_SQ: begin
                o_cmd.ld_sq = 1'b1;
                n_cnt       = LAST;
                n_state     = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_SQ_END;
                end
            end
            ST_SQ_END: begin
                o_cmd.save_acc = 1'b1;
                n_state        = i_status.exp_msb ? ST_LD_MUL : ST_NEXT;
            end
            ST_LD_MUL: begin
                o_cmd.ld_mul = 1'b1;
                n_cnt        = LAST;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_MUL_END;
                end
            end
            ST_MUL_END: begin
                o_cmd.save_acc = 1'b1;
                n_state        = ST_NEXT;
            end
            ST_NEXT: begin
                o_cmd.shift_exp = 1'b1;
                n_bit           = r_bit - CW'(1);
                n_state         = (r_bit == '0) ? ST_DONE : ST_LD_SQ;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/modular_exponentiation_top.sv =====
// Modular exponentiation: o_power_result = i_base_value ^ exponent mod modulus, by
// left-to-right square-and-multiply over all WIDTH exponent bits. An item is taken
// when start is high and busy is low; the result appears for one cycle with o_done
// and must be captured then, since the block cannot be stalled. busy stays high
// until that cycle ends. One shared shift-add-reduce unit does every modular
// product one multiplier bit per cycle, and also reduces the base first by long
// division. A zero exponent returns 1 in the cycle after the accepting edge, and
// the next item can be taken in the cycle after the result.
// Write modulus (index 0) and exponent (index 1) only while busy is low.
`default_nettype none

module modular_exponentiation_top
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WIDTH-1:0]     i_cfg_data,
    input  wire logic                 start,
    input  wire logic [WIDTH-1:0]     i_base_value,
    output logic                      busy,
    output logic                      o_done,
    output logic [WIDTH-1:0]          o_power_result
);

    t_dp_cmd    cmd;
    t_dp_status status;

    mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    mexp_datapath #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_base_value   (i_base_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_power_result (o_power_result)
    );

endmodule

`default_nettype wire

// ===== hdl/mexp_checker.sv =====
`default_nettype none

module mexp_checker
    import mexp_pkg::*;
#(
    parameter int unsigned WIDTH = 16
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_we,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_done,
    input wire logic [WIDTH-1:0]     o_power_result
);

    // reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_done))
        else $error("block not idle after reset");

    // an accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // a result only comes while an item is in flight
    a_done_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // one strobe per item, then ready for the next
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe not followed by idle");

    // zero exponent gives 1
    a_done_value_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_cfg_we && !o_done) ##1 o_done |-> (o_power_result == WIDTH'(1)))
        else $error("two-cycle result is not one");

endmodule

bind modular_exponentiation_top mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);

`default_nettype wire
